FILE: rtl/bfs_pkg.sv
// Package for the breadth-first search core: sizes, action and status codes,
// and the command and status structs between controller and datapath.
// No dependencies; every other file in rtl/ but bfs_ram refers to it by scoped names.
package bfs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;

	// Fixed field widths of the item, the result status and the vertex count register.
	localparam int ACTION_W = 2;
	localparam int VERT_W   = 6;
	localparam int STATUS_W = 2;
	localparam int VCOUNT_W = 7;

	// Widths derived from the store sizes.
	localparam int VIDX_W     = $clog2(MAX_VERTICES);
	localparam int QPTR_W     = $clog2(MAX_VERTICES + 1);
	localparam int EIDX_W     = $clog2(MAX_EDGES);
	localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
	localparam int EDGE_RAM_W = VIDX_W + 1 + EIDX_W;

	localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic                accept;
		logic                load_status;
		logic [STATUS_W-1:0] status;
		logic                add_commit;
		logic                clear_lists;
		logic                trav_init;
		logic                fifo_pop;
		logic                head_rd_cur;
		logic                load_cur;
		logic                edge_rd_head;
		logic                edge_visit;
		logic                push_result;
		logic                push_pend;
		logic                push_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                edge_ok;
		logic                start_ok;
		logic                full;
		logic                q_nonempty;
		logic                pend_valid;
		logic                head_ok;
		logic                next_valid;
		logic                out_free;
	} dp_status_t;

endpackage

FILE: rtl/bfs_req_if.sv
// Request channel of the breadth-first search core: valid/ready and one item.
// Depends on bfs_pkg for field widths.
interface bfs_req_if;
	logic                          valid;
	logic                          ready;
	logic [bfs_pkg::ACTION_W-1:0]  action;
	logic [bfs_pkg::VERT_W-1:0]    source_vertex;
	logic [bfs_pkg::VERT_W-1:0]    target_vertex;
	logic [bfs_pkg::VERT_W-1:0]    start_vertex;

	modport source (output valid, action, source_vertex, target_vertex, start_vertex,
		input ready);
	modport sink (input valid, action, source_vertex, target_vertex, start_vertex,
		output ready);
endinterface

FILE: rtl/bfs_res_if.sv
// Result channel of the breadth-first search core: valid/ready and one item.
// Depends on bfs_pkg for field widths.
interface bfs_res_if;
	logic                          valid;
	logic                          ready;
	logic [bfs_pkg::VERT_W-1:0]    visited_vertex;
	logic                          last_result;
	logic [bfs_pkg::STATUS_W-1:0]  status;

	modport source (output valid, visited_vertex, last_result, status, input ready);
	modport sink (input valid, visited_vertex, last_result, status, output ready);
endinterface

FILE: rtl/bfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/bfs_cfg.sv
// APB-style configuration register block holding vertex_count.
// Depends on bfs_pkg for the address map and reset value.
module bfs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfs_pkg::PADDR_W-1:0]   paddr,
	input  logic [bfs_pkg::PDATA_W-1:0]   pwdata,
	output logic [bfs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [bfs_pkg::VCOUNT_W-1:0]  vertex_count
);

	logic [bfs_pkg::VCOUNT_W-1:0] vertex_count_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready
		&& (paddr == bfs_pkg::ADDR_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= bfs_pkg::VCOUNT_RESET;
		end else if (wr_en) begin
			vertex_count_q <= pwdata[bfs_pkg::VCOUNT_W-1:0];
		end
	end

	assign prdata = (paddr == bfs_pkg::ADDR_VERTEX_COUNT)
		? bfs_pkg::PDATA_W'(vertex_count_q) : '0;
	assign vertex_count = vertex_count_q;

endmodule

FILE: rtl/bfs_ctrl.sv
// Controller state machine of the breadth-first search core.
// Depends on bfs_pkg for the command and status structs and the codes.
module bfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bfs_pkg::dp_status_t st,
	output bfs_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_ADD_WR = 3'd2;
	localparam logic [2:0] S_RESULT = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;
	localparam logic [2:0] S_HEAD   = 3'd5;
	localparam logic [2:0] S_LIST   = 3'd6;
	localparam logic [2:0] S_EDGE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.action)
					bfs_pkg::ACT_ADD: begin
						if (!st.edge_ok) begin
							cmd.load_status = 1'b1;
							cmd.status      = bfs_pkg::ST_RANGE;
							state_nxt       = S_RESULT;
						end else if (st.full) begin
							cmd.load_status = 1'b1;
							cmd.status      = bfs_pkg::ST_FULL;
							state_nxt       = S_RESULT;
						end else begin
							// The head of the source list is being read this cycle.
							state_nxt = S_ADD_WR;
						end
					end
					bfs_pkg::ACT_CLEAR: begin
						cmd.clear_lists = 1'b1;
						cmd.load_status = 1'b1;
						cmd.status      = bfs_pkg::ST_OK;
						state_nxt       = S_RESULT;
					end
					bfs_pkg::ACT_TRAVERSE: begin
						if (!st.start_ok) begin
							cmd.load_status = 1'b1;
							cmd.status      = bfs_pkg::ST_RANGE;
							state_nxt       = S_RESULT;
						end else begin
							cmd.trav_init = 1'b1;
							state_nxt     = S_POP;
						end
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_ADD_WR: begin
				cmd.add_commit  = 1'b1;
				cmd.load_status = 1'b1;
				cmd.status      = bfs_pkg::ST_OK;
				state_nxt       = S_RESULT;
			end
			S_RESULT: begin
				if (st.out_free) begin
					cmd.push_result = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			S_POP: begin
				// The vertex popped before is sent only once it is known whether it is last.
				if (st.q_nonempty) begin
					if (!st.pend_valid || st.out_free) begin
						cmd.push_pend = st.pend_valid;
						cmd.fifo_pop  = 1'b1;
						state_nxt     = S_HEAD;
					end
				end else if (st.out_free) begin
					cmd.push_pend = 1'b1;
					cmd.push_last = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_HEAD: begin
				cmd.load_cur    = 1'b1;
				cmd.head_rd_cur = 1'b1;
				state_nxt       = S_LIST;
			end
			S_LIST: begin
				if (st.head_ok) begin
					cmd.edge_rd_head = 1'b1;
					state_nxt        = S_EDGE;
				end else begin
					state_nxt = S_POP;
				end
			end
			S_EDGE: begin
				cmd.edge_visit = 1'b1;
				if (!st.next_valid) begin
					state_nxt = S_POP;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/bfs_dp.sv
// Datapath of the breadth-first search core: item registers, list heads,
// edge store, visit queue, visited marks and the result register.
// Depends on bfs_pkg and bfs_ram.
module bfs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfs_pkg::dp_cmd_t              cmd,
	output bfs_pkg::dp_status_t           st,
	input  logic [bfs_pkg::VCOUNT_W-1:0]  vertex_count,
	input  logic [bfs_pkg::ACTION_W-1:0]  action,
	input  logic [bfs_pkg::VERT_W-1:0]    source_vertex,
	input  logic [bfs_pkg::VERT_W-1:0]    target_vertex,
	input  logic [bfs_pkg::VERT_W-1:0]    start_vertex,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bfs_pkg::VERT_W-1:0]    visited_vertex,
	output logic                          last_result,
	output logic [bfs_pkg::STATUS_W-1:0]  status
);

	localparam int VIDX_W = bfs_pkg::VIDX_W;
	localparam int EIDX_W = bfs_pkg::EIDX_W;
	localparam int QPTR_W = bfs_pkg::QPTR_W;
	localparam int VCW    = bfs_pkg::VCOUNT_W;

	// Item registers.
	logic [bfs_pkg::ACTION_W-1:0] action_q;
	logic [bfs_pkg::VERT_W-1:0]   src_q;
	logic [bfs_pkg::VERT_W-1:0]   dst_q;
	logic [bfs_pkg::VERT_W-1:0]   start_q;

	logic [bfs_pkg::ECNT_W-1:0]     edges_used_q;
	logic [bfs_pkg::MAX_VERTICES-1:0] head_valid_q;
	logic [bfs_pkg::MAX_VERTICES-1:0] seen_q;
	logic [QPTR_W-1:0]              rptr_q;
	logic [QPTR_W-1:0]              wptr_q;
	logic [VIDX_W-1:0]              pend_q;
	logic                           pend_valid_q;
	logic                           head_ok_q;
	logic [bfs_pkg::STATUS_W-1:0]   res_status_q;

	logic                           out_valid_q;
	logic [bfs_pkg::VERT_W-1:0]     out_vertex_q;
	logic                           out_last_q;
	logic [bfs_pkg::STATUS_W-1:0]   out_status_q;

	logic [VCW-1:0]    nv;
	logic              out_free;

	logic [VIDX_W-1:0] head_raddr;
	logic [EIDX_W-1:0] head_rdata;

	logic [EIDX_W-1:0]              edge_raddr;
	logic [bfs_pkg::EDGE_RAM_W-1:0] edge_wdata;
	logic [bfs_pkg::EDGE_RAM_W-1:0] edge_rdata;
	logic [VIDX_W-1:0]              edge_tgt;
	logic                           edge_nvalid;
	logic [EIDX_W-1:0]              edge_next;

	logic              fifo_we;
	logic [VIDX_W-1:0] fifo_waddr;
	logic [VIDX_W-1:0] fifo_wdata;
	logic [VIDX_W-1:0] fifo_rdata;
	logic              enqueue;

	logic [VIDX_W-1:0] src_idx;
	logic [VIDX_W-1:0] dst_idx;
	logic [VIDX_W-1:0] start_idx;

	assign nv = (vertex_count > VCW'(bfs_pkg::MAX_VERTICES))
		? VCW'(bfs_pkg::MAX_VERTICES) : vertex_count;

	assign src_idx   = src_q[VIDX_W-1:0];
	assign dst_idx   = dst_q[VIDX_W-1:0];
	assign start_idx = start_q[VIDX_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	// Edge word: target, valid bit of the next link, next edge index.
	assign edge_tgt    = edge_rdata[bfs_pkg::EDGE_RAM_W-1 -: VIDX_W];
	assign edge_nvalid = edge_rdata[EIDX_W];
	assign edge_next   = edge_rdata[EIDX_W-1:0];
	assign edge_wdata  = {dst_idx, head_valid_q[src_idx], head_rdata};

	assign head_raddr = cmd.head_rd_cur ? fifo_rdata : src_idx;
	assign edge_raddr = cmd.edge_rd_head ? head_rdata : edge_next;

	assign enqueue = cmd.edge_visit && (VCW'(edge_tgt) < nv) && !seen_q[edge_tgt]
		&& (wptr_q < QPTR_W'(bfs_pkg::MAX_VERTICES));

	assign fifo_we    = cmd.trav_init || enqueue;
	assign fifo_waddr = cmd.trav_init ? '0 : wptr_q[VIDX_W-1:0];
	assign fifo_wdata = cmd.trav_init ? start_idx : edge_tgt;

	bfs_ram #(
		.WIDTH(EIDX_W),
		.DEPTH(bfs_pkg::MAX_VERTICES)
	) u_head_ram (
		.clk  (clk),
		.we   (cmd.add_commit),
		.waddr(src_idx),
		.wdata(edges_used_q[EIDX_W-1:0]),
		.raddr(head_raddr),
		.rdata(head_rdata)
	);

	bfs_ram #(
		.WIDTH(bfs_pkg::EDGE_RAM_W),
		.DEPTH(bfs_pkg::MAX_EDGES)
	) u_edge_ram (
		.clk  (clk),
		.we   (cmd.add_commit),
		.waddr(edges_used_q[EIDX_W-1:0]),
		.wdata(edge_wdata),
		.raddr(edge_raddr),
		.rdata(edge_rdata)
	);

	bfs_ram #(
		.WIDTH(VIDX_W),
		.DEPTH(bfs_pkg::MAX_VERTICES)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_we),
		.waddr(fifo_waddr),
		.wdata(fifo_wdata),
		.raddr(rptr_q[VIDX_W-1:0]),
		.rdata(fifo_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action;
			src_q    <= source_vertex;
			dst_q    <= target_vertex;
			start_q  <= start_vertex;
		end
		if (cmd.load_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.load_cur) begin
			pend_q    <= fifo_rdata;
			head_ok_q <= head_valid_q[fifo_rdata];
		end
		if (cmd.push_result) begin
			out_vertex_q <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= res_status_q;
		end else if (cmd.push_pend) begin
			out_vertex_q <= bfs_pkg::VERT_W'(pend_q);
			out_last_q   <= cmd.push_last;
			out_status_q <= bfs_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_used_q <= '0;
			head_valid_q <= '0;
			seen_q       <= '0;
			rptr_q       <= '0;
			wptr_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_lists) begin
				edges_used_q <= '0;
				head_valid_q <= '0;
			end else if (cmd.add_commit) begin
				edges_used_q          <= edges_used_q + 1'b1;
				head_valid_q[src_idx] <= 1'b1;
			end

			if (cmd.trav_init) begin
				seen_q       <= {{(bfs_pkg::MAX_VERTICES-1){1'b0}}, 1'b1} << start_idx;
				rptr_q       <= '0;
				wptr_q       <= QPTR_W'(1);
				pend_valid_q <= 1'b0;
			end else begin
				if (enqueue) begin
					seen_q[edge_tgt] <= 1'b1;
					wptr_q           <= wptr_q + 1'b1;
				end
				if (cmd.fifo_pop) begin
					rptr_q <= rptr_q + 1'b1;
				end
				if (cmd.load_cur) begin
					pend_valid_q <= 1'b1;
				end
			end

			if (cmd.push_result || cmd.push_pend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.action     = action_q;
	assign st.edge_ok    = (VCW'(src_q) < nv) && (VCW'(dst_q) < nv);
	assign st.start_ok   = VCW'(start_q) < nv;
	assign st.full       = edges_used_q >= bfs_pkg::ECNT_W'(bfs_pkg::MAX_EDGES);
	assign st.q_nonempty = (rptr_q < wptr_q) && (rptr_q < QPTR_W'(bfs_pkg::MAX_VERTICES));
	assign st.pend_valid = pend_valid_q;
	assign st.head_ok    = head_ok_q;
	assign st.next_valid = edge_nvalid;
	assign st.out_free   = out_free;

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign last_result    = out_last_q;
	assign status         = out_status_q;

endmodule

FILE: rtl/bfs_graph_traversal_core.sv
// Breadth-first search core over per-vertex edge lists held in block RAM.
// Traverse walks the edge list of each visited vertex, one edge-RAM read a cycle;
// a new item is taken once the previous item's last result is in the output register.
// Reset clears all lists, the edge count, visited marks and queue pointers at once;
// vertex_count resets to 64. Depends on bfs_pkg, the channel interfaces and submodules.
module bfs_graph_traversal_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bfs_req_if.sink                       request,
	bfs_res_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfs_pkg::PADDR_W-1:0]   paddr,
	input  logic [bfs_pkg::PDATA_W-1:0]   pwdata,
	output logic [bfs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [bfs_pkg::VCOUNT_W-1:0] vertex_count;
	bfs_pkg::dp_cmd_t             cmd;
	bfs_pkg::dp_status_t          st;
	logic                         in_ready;

	bfs_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.vertex_count(vertex_count)
	);

	bfs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(request.valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	bfs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.vertex_count  (vertex_count),
		.action        (request.action),
		.source_vertex (request.source_vertex),
		.target_vertex (request.target_vertex),
		.start_vertex  (request.start_vertex),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.visited_vertex(result.visited_vertex),
		.last_result   (result.last_result),
		.status        (result.status)
	);

	assign request.ready = in_ready;

endmodule

FILE: tb/sv/bfs_graph_traversal_core_tb.sv
// Self-checking testbench for bfs_graph_traversal_core: edge inserts, clears and
// breadth-first walks checked against an in-bench graph predictor.
// Depends on bfs_pkg, bfs_req_if, bfs_res_if and the core itself.
`timescale 1ns / 100ps

module bfs_graph_traversal_core_tb;
	import bfs_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
	localparam int IDLE_PCT    = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 24;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [VERT_W-1:0]   src;
		logic [VERT_W-1:0]   dst;
		logic [VERT_W-1:0]   start;
	} graph_cmd_t;

	typedef struct {
		logic [VERT_W-1:0]   vertex;
		logic                last;
		logic [STATUS_W-1:0] status;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bfs_req_if req_ch ();
	bfs_res_if res_ch ();

	bfs_graph_traversal_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the graph store and the search state.
	logic [VCOUNT_W-1:0] vcount_cfg = VCOUNT_RESET;
	logic [8:0]          head_idx [MAX_VERTICES];
	bit                  head_ok  [MAX_VERTICES];
	logic [VERT_W-1:0]   edge_dst [MAX_EDGES];
	logic [8:0]          edge_nxt [MAX_EDGES];
	bit                  nxt_ok   [MAX_EDGES];
	int                  edge_cnt = 0;
	bit                  seen     [MAX_VERTICES];
	logic [VERT_W-1:0]   visit_fifo [MAX_VERTICES];

	graph_cmd_t cmd_queue [$];
	visit_t     want_visits [$];
	graph_cmd_t cur_cmd;
	bit         calm = 1'b0;

	int err_cnt = 0;
	int items_taken = 0;
	int visits_checked = 0;
	int walks_cnt = 0;
	int full_cnt = 0;
	int range_cnt = 0;
	int settings_cnt = 0;
	int stall_cnt = 0;

	function automatic int eff_vertices();
		return (int'(vcount_cfg) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_cfg);
	endfunction

	function automatic void push_visit(logic [VERT_W-1:0] v, logic last, logic [STATUS_W-1:0] st);
		visit_t r;
		r.vertex = v;
		r.last = last;
		r.status = st;
		want_visits.push_back(r);
	endfunction

	// Works out the results of one accepted item and updates the shadow graph.
	function automatic void walk_graph(graph_cmd_t c);
		int nv;
		int rd;
		int wr;
		int e;
		int guard;
		int t;
		bit ok;
		bit have_prev;
		logic [VERT_W-1:0] cur;
		logic [VERT_W-1:0] prev;
		nv = eff_vertices();
		have_prev = 1'b0;
		prev = '0;
		case (c.action)
			ACT_ADD: begin
				if (int'(c.src) >= nv || int'(c.dst) >= nv) begin
					push_visit('0, 1'b1, ST_RANGE);
					range_cnt++;
				end else if (edge_cnt >= MAX_EDGES) begin
					push_visit('0, 1'b1, ST_FULL);
					full_cnt++;
				end else begin
					edge_dst[edge_cnt] = c.dst;
					edge_nxt[edge_cnt] = head_idx[c.src];
					nxt_ok[edge_cnt] = head_ok[c.src];
					head_idx[c.src] = 9'(edge_cnt);
					head_ok[c.src] = 1'b1;
					edge_cnt++;
					push_visit('0, 1'b1, ST_OK);
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < MAX_VERTICES; i++) begin
					head_ok[i] = 1'b0;
					head_idx[i] = '0;
				end
				edge_cnt = 0;
				push_visit('0, 1'b1, ST_OK);
			end
			ACT_TRAVERSE: begin
				if (int'(c.start) >= nv) begin
					push_visit('0, 1'b1, ST_RANGE);
					range_cnt++;
				end else begin
					walks_cnt++;
					for (int i = 0; i < MAX_VERTICES; i++)
						seen[i] = 1'b0;
					seen[c.start] = 1'b1;
					visit_fifo[0] = c.start;
					rd = 0;
					wr = 1;
					while (rd < wr && rd < MAX_VERTICES) begin
						cur = visit_fifo[rd];
						rd++;
						// The last flag is only known once the queue runs dry.
						if (have_prev)
							push_visit(prev, 1'b0, ST_OK);
						prev = cur;
						have_prev = 1'b1;
						ok = head_ok[cur];
						e = int'(head_idx[cur]);
						guard = 0;
						while (ok && e < MAX_EDGES && guard < MAX_EDGES) begin
							t = int'(edge_dst[e]);
							if (t < nv && !seen[t] && wr < MAX_VERTICES) begin
								seen[t] = 1'b1;
								visit_fifo[wr] = VERT_W'(t);
								wr++;
							end
							ok = nxt_ok[e];
							e = int'(edge_nxt[e]);
							guard++;
						end
					end
					push_visit(prev, 1'b1, ST_OK);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_cmd(logic [ACTION_W-1:0] act, int s, int d, int st);
		graph_cmd_t c;
		c.action = act;
		c.src = VERT_W'(s);
		c.dst = VERT_W'(d);
		c.start = VERT_W'(st);
		cmd_queue.push_back(c);
	endfunction

	// Mostly in-range inserts and walks so the graph grows deep; the rest is noise.
	function automatic void queue_random_cmd();
		graph_cmd_t c;
		int nv;
		int pick;
		nv = eff_vertices();
		c.action = ACT_ADD;
		c.src = VERT_W'($urandom_range(63));
		c.dst = VERT_W'($urandom_range(63));
		c.start = VERT_W'($urandom_range(63));
		pick = $urandom_range(99);
		if (pick < 62 && nv > 0) begin
			c.src = VERT_W'($urandom_range(nv - 1));
			c.dst = VERT_W'($urandom_range(nv - 1));
		end else if (pick < 78 && nv > 0) begin
			c.action = ACT_TRAVERSE;
			c.start = VERT_W'($urandom_range(nv - 1));
		end else if (pick < 86) begin
			c.action = ACT_ADD;
		end else if (pick < 92) begin
			c.action = ACT_TRAVERSE;
		end else if (pick < 96) begin
			c.action = ACT_CLEAR;
		end else begin
			c.action = ACT_IGNORED;
		end
		cmd_queue.push_back(c);
	endfunction

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.action <= '0;
			req_ch.source_vertex <= '0;
			req_ch.target_vertex <= '0;
			req_ch.start_vertex <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				walk_graph(cur_cmd);
				items_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cur_cmd = cmd_queue.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= cur_cmd.action;
					req_ch.source_vertex <= cur_cmd.src;
					req_ch.target_vertex <= cur_cmd.dst;
					req_ch.start_vertex <= cur_cmd.start;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		visit_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (want_visits.size() == 0) begin
				$error("unexpected result: visited_vertex %0d last_result %0d status %0d",
					res_ch.visited_vertex, res_ch.last_result, res_ch.status);
				err_cnt++;
			end else begin
				w = want_visits.pop_front();
				visits_checked++;
				if (res_ch.visited_vertex !== w.vertex) begin
					$error("visited_vertex: expected %0d, actual %0d", w.vertex,
						res_ch.visited_vertex);
					err_cnt++;
				end
				if (res_ch.last_result !== w.last) begin
					$error("last_result: expected %0d, actual %0d", w.last, res_ch.last_result);
					err_cnt++;
				end
				if (res_ch.status !== w.status) begin
					$error("status: expected %0d, actual %0d", w.status, res_ch.status);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel and no configuration access.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmd_queue.size() != 0 || req_ch.valid || want_visits.size() != 0);
		// An ignored item gives nothing to wait for, so allow it to pass through.
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_vertex_count(logic [PDATA_W-1:0] wdata);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_VERTEX_COUNT;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		vcount_cfg = wdata[VCOUNT_W-1:0];
		settings_cnt++;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[VCOUNT_W-1:0] !== vcount_cfg) begin
			$error("vertex_count readback: expected %0d, actual %0d", vcount_cfg,
				prdata[VCOUNT_W-1:0]);
			err_cnt++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			queue_random_cmd();
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			head_ok[i] = 1'b0;
			head_idx[i] = '0;
			seen[i] = 1'b0;
		end
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme vertices, a self loop, a repeated target, an isolated
		// start, the ignored code and a clear, all at the reset vertex count.
		queue_cmd(ACT_ADD, 0, 63, 0);
		queue_cmd(ACT_ADD, 63, 0, 63);
		queue_cmd(ACT_ADD, 0, 1, 0);
		queue_cmd(ACT_ADD, 1, 2, 0);
		queue_cmd(ACT_ADD, 0, 2, 0);
		queue_cmd(ACT_ADD, 5, 5, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 0);
		queue_cmd(ACT_TRAVERSE, 63, 63, 63);
		queue_cmd(ACT_TRAVERSE, 0, 0, 5);
		queue_cmd(ACT_TRAVERSE, 0, 0, 10);
		queue_cmd(ACT_IGNORED, 63, 63, 63);
		queue_cmd(ACT_CLEAR, 0, 0, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 0);
		queue_cmd(ACT_ADD, 3, 4, 0);
		queue_cmd(ACT_ADD, 3, 40, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 3);
		wait_drained();

		// Lowered count: range rejections and an edge whose target went stale.
		set_vertex_count(32'd8);
		queue_cmd(ACT_ADD, 9, 1, 0);
		queue_cmd(ACT_ADD, 1, 9, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 8);
		queue_cmd(ACT_TRAVERSE, 0, 0, 3);
		wait_drained();

		set_vertex_count(32'd0);
		queue_cmd(ACT_ADD, 0, 0, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 0);
		wait_drained();

		set_vertex_count(32'd1);
		queue_cmd(ACT_ADD, 0, 0, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 0);
		queue_cmd(ACT_ADD, 0, 1, 0);
		wait_drained();

		// All ones: the count reads as 127 and acts as the full vertex range.
		set_vertex_count(32'hFFFF_FFFF);
		queue_cmd(ACT_TRAVERSE, 0, 0, 63);
		queue_cmd(ACT_ADD, 63, 63, 0);
		wait_drained();

		set_vertex_count(32'h5A5A_0028);
		run_random(15);
		set_vertex_count(32'd8);
		run_random(10);
		set_vertex_count(32'd64);
		run_random(15);

		// Fill the edge store to the limit with no idling, walking now and then.
		calm = 1'b1;
		queue_cmd(ACT_CLEAR, 0, 0, 0);
		for (int i = 0; i < MAX_EDGES; i++) begin
			queue_cmd(ACT_ADD, $urandom_range(63), $urandom_range(63), 0);
			if (i % 24 == 23)
				queue_cmd(ACT_TRAVERSE, 0, 0, $urandom_range(63));
		end
		queue_cmd(ACT_ADD, 12, 34, 0);
		queue_cmd(ACT_ADD, 63, 0, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, $urandom_range(63));
		wait_drained();
		set_vertex_count(32'd70);
		queue_cmd(ACT_ADD, 1, 2, 0);
		queue_cmd(ACT_TRAVERSE, 0, 0, 0);
		queue_cmd(ACT_CLEAR, 0, 0, 0);
		queue_cmd(ACT_ADD, 1, 2, 0);
		wait_drained();
		calm = 1'b0;

		set_vertex_count(32'd2);
		run_random(5);
		set_vertex_count(32'd64);
		run_random(10);

		$display("Checked %0d results from %0d items across %0d vertex_count settings.",
			visits_checked, items_taken, settings_cnt);
		$display("Walks: %0d, full-store rejections: %0d, range rejections: %0d.",
			walks_cnt, full_cnt, range_cnt);
		if (err_cnt == 0 && want_visits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bfs_pkg.sv
rtl/bfs_req_if.sv
rtl/bfs_res_if.sv
rtl/bfs_ram.sv
rtl/bfs_cfg.sv
rtl/bfs_ctrl.sv
rtl/bfs_dp.sv
rtl/bfs_graph_traversal_core.sv
tb/sv/bfs_graph_traversal_core_tb.sv
